// File: rtl/core/aesbe_pkg.sv
// Shared types, S-box table and GF(2^8) helpers for the AES block encryptor.
// No dependencies.
package aesbe_pkg;

    localparam int RKI_W = 6;   // round key word index width (up to 64 words)

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic             go;       // start key expansion
        logic             rd_en;    // read a round key word
        logic [RKI_W-1:0] rd_idx;
    } t_ks_req;

    typedef enum logic [1:0] {
        KS_128 = 2'd0,
        KS_192 = 2'd1,
        KS_256 = 2'd2
    } t_key_size;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_SIZE  = 3'd0;
    localparam logic [2:0] REG_KEY_0_7   = 3'd1;
    localparam logic [2:0] REG_KEY_8_15  = 3'd2;
    localparam logic [2:0] REG_KEY_16_23 = 3'd3;
    localparam logic [2:0] REG_KEY_24_31 = 3'd4;

    localparam logic [7:0] SBOX [256] = '{
        8'd99, 8'd124, 8'd119, 8'd123, 8'd242, 8'd107, 8'd111, 8'd197,
        8'd48, 8'd1, 8'd103, 8'd43, 8'd254, 8'd215, 8'd171, 8'd118,
        8'd202, 8'd130, 8'd201, 8'd125, 8'd250, 8'd89, 8'd71, 8'd240,
        8'd173, 8'd212, 8'd162, 8'd175, 8'd156, 8'd164, 8'd114, 8'd192,
        8'd183, 8'd253, 8'd147, 8'd38, 8'd54, 8'd63, 8'd247, 8'd204,
        8'd52, 8'd165, 8'd229, 8'd241, 8'd113, 8'd216, 8'd49, 8'd21,
        8'd4, 8'd199, 8'd35, 8'd195, 8'd24, 8'd150, 8'd5, 8'd154,
        8'd7, 8'd18, 8'd128, 8'd226, 8'd235, 8'd39, 8'd178, 8'd117,
        8'd9, 8'd131, 8'd44, 8'd26, 8'd27, 8'd110, 8'd90, 8'd160,
        8'd82, 8'd59, 8'd214, 8'd179, 8'd41, 8'd227, 8'd47, 8'd132,
        8'd83, 8'd209, 8'd0, 8'd237, 8'd32, 8'd252, 8'd177, 8'd91,
        8'd106, 8'd203, 8'd190, 8'd57, 8'd74, 8'd76, 8'd88, 8'd207,
        8'd208, 8'd239, 8'd170, 8'd251, 8'd67, 8'd77, 8'd51, 8'd133,
        8'd69, 8'd249, 8'd2, 8'd127, 8'd80, 8'd60, 8'd159, 8'd168,
        8'd81, 8'd163, 8'd64, 8'd143, 8'd146, 8'd157, 8'd56, 8'd245,
        8'd188, 8'd182, 8'd218, 8'd33, 8'd16, 8'd255, 8'd243, 8'd210,
        8'd205, 8'd12, 8'd19, 8'd236, 8'd95, 8'd151, 8'd68, 8'd23,
        8'd196, 8'd167, 8'd126, 8'd61, 8'd100, 8'd93, 8'd25, 8'd115,
        8'd96, 8'd129, 8'd79, 8'd220, 8'd34, 8'd42, 8'd144, 8'd136,
        8'd70, 8'd238, 8'd184, 8'd20, 8'd222, 8'd94, 8'd11, 8'd219,
        8'd224, 8'd50, 8'd58, 8'd10, 8'd73, 8'd6, 8'd36, 8'd92,
        8'd194, 8'd211, 8'd172, 8'd98, 8'd145, 8'd149, 8'd228, 8'd121,
        8'd231, 8'd200, 8'd55, 8'd109, 8'd141, 8'd213, 8'd78, 8'd169,
        8'd108, 8'd86, 8'd244, 8'd234, 8'd101, 8'd122, 8'd174, 8'd8,
        8'd186, 8'd120, 8'd37, 8'd46, 8'd28, 8'd166, 8'd180, 8'd198,
        8'd232, 8'd221, 8'd116, 8'd31, 8'd75, 8'd189, 8'd139, 8'd138,
        8'd112, 8'd62, 8'd181, 8'd102, 8'd72, 8'd3, 8'd246, 8'd14,
        8'd97, 8'd53, 8'd87, 8'd185, 8'd134, 8'd193, 8'd29, 8'd158,
        8'd225, 8'd248, 8'd152, 8'd17, 8'd105, 8'd217, 8'd142, 8'd148,
        8'd155, 8'd30, 8'd135, 8'd233, 8'd206, 8'd85, 8'd40, 8'd223,
        8'd140, 8'd161, 8'd137, 8'd13, 8'd191, 8'd230, 8'd66, 8'd104,
        8'd65, 8'd153, 8'd45, 8'd15, 8'd176, 8'd84, 8'd187, 8'd22
    };

    function automatic t_byte sbox(input t_byte a);
        return SBOX[a];
    endfunction

    function automatic t_byte xtime(input t_byte b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // key words per key size; the unused code runs as a 256-bit key
    function automatic logic [3:0] key_words(input logic [1:0] ks);
        case (ks)
            KS_128:  return 4'd4;
            KS_192:  return 4'd6;
            default: return 4'd8;
        endcase
    endfunction

endpackage

// File: rtl/core/aesbe_keyexp.sv
// Round key expansion, one word per cycle, into the round key memory.
// Depends on aesbe_pkg.
module aesbe_keyexp #(
    parameter int DEPTH = 60
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  aesbe_pkg::t_ks_req    i_req,
    input  logic [1:0]            i_key_size,
    input  logic [3:0][63:0]      i_key,
    output logic                  o_done,
    output logic [31:0]           o_rdata
);
    import aesbe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [RKI_W-1:0] DEPTH_W = RKI_W'(DEPTH);

    logic [31:0]      r_mem [DEPTH];
    logic             r_run, r_done, r_rz;
    logic [RKI_W-1:0] r_i;
    logic [2:0]       r_kc;
    logic [7:0]       r_rcon;
    logic [31:0]      r_win [8];    // r_win[0] is word i-1
    logic [31:0]      r_rdata;

    logic [3:0]       nk;
    logic [RKI_W-1:0] total_m1;
    logic [2:0]       nk_m1;
    logic [63:0]      kreg;
    logic [31:0]      t, n_word, n_push;
    logic             in_range;

    assign nk       = key_words(i_key_size);
    assign nk_m1    = 3'(nk - 4'd1);
    assign total_m1 = RKI_W'(6'd4 * {2'b00, nk} + 6'd27);
    assign in_range = (r_i < DEPTH_W);
    assign kreg     = i_key[r_i[2:1]];

    always_comb begin
        t = r_win[0];
        if (r_kc == 3'd0) begin
            t = sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rcon, 24'h0};
        end else if (nk == 4'd8 && r_kc == 3'd4) begin
            t = sub_word(r_win[0]);
        end
        if (r_i < RKI_W'(nk)) begin
            n_word = r_i[0] ? kreg[31:0] : kreg[63:32];
        end else begin
            n_word = r_win[nk_m1] ^ t;
        end
        // words past the end of a shallow store go into the window as zero, and read back as zero
        n_push = in_range ? n_word : 32'h0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
            r_kc   <= '0;
            r_rcon <= 8'h01;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_run  <= 1'b1;
                r_i    <= '0;
                r_kc   <= '0;
                r_rcon <= 8'h01;
            end else if (r_run) begin
                if (r_i >= RKI_W'(nk) && r_kc == 3'd0) begin
                    r_rcon <= xtime(r_rcon);
                end
                r_kc <= (r_kc == nk_m1) ? 3'd0 : r_kc + 3'd1;
                if (r_i == total_m1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + RKI_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_run) begin
            r_win[0] <= n_push;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_run && in_range) begin
            r_mem[r_i[AW-1:0]] <= n_word;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_idx[AW-1:0]];
            r_rz    <= (i_req.rd_idx >= DEPTH_W);
        end
    end

    assign o_done  = r_done;
    assign o_rdata = r_rz ? 32'h0 : r_rdata;

endmodule

// File: rtl/core/aes_block_encrypt_top.sv
// AES-128/192/256 ECB block encryptor, top level with column-serial datapath.
// Depends on aesbe_pkg and aesbe_keyexp.
//
// Each item first expands the round keys, one key word per cycle, then runs
// the cipher one state column per cycle, where each column step does four
// S-box lookups (none in the initial round), MixColumns (not in the initial
// or last round) and the round key XOR. Between start and result lie the
// registered handoffs from start to expansion, expansion done, first key read
// and the result register. busy falls as o_valid rises, so the next start
// can be taken at the edge that takes the result; a new block is not taken
// before the last one is through. The result shows on o_cipher_hi/o_cipher_lo
// with o_valid, high for one cycle, and holds until the next result; the
// receiver cannot stall it. Start is taken only while busy is low.
module aes_block_encrypt_top #(
    parameter int ROUND_KEY_DEPTH = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_block_hi,
    input  logic [63:0] i_block_lo,
    output logic        o_valid,
    output logic [63:0] o_cipher_hi,
    output logic [63:0] o_cipher_lo
);
    import aesbe_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EXPAND, S_RUN} t_state;

    t_state           r_state;
    logic             r_busy, r_valid;
    logic [1:0]       r_key_size;
    logic [3:0][63:0] r_key;
    t_byte            r_st [16];
    t_byte            r_nx [16];
    logic [63:0]      r_hi, r_lo;
    logic             r_iss, r_p;
    logic [RKI_W-1:0] r_j, r_pj;
    logic             r_go;

    t_ks_req          ks_req;
    logic             ks_done;
    logic [31:0]      rk;

    logic [3:0]       nr;
    logic [RKI_W-1:0] last_j;
    logic [1:0]       col;
    logic [3:0]       rnd;
    t_byte            tmp [16];
    t_byte            sb [4];
    t_byte            all_x;

    assign nr     = key_words(r_key_size) + 4'd6;
    assign last_j = RKI_W'(6'd4 * {2'b00, nr} + 6'd3);
    assign col    = r_pj[1:0];
    assign rnd    = r_pj[5:2];

    assign ks_req.go     = r_go;
    assign ks_req.rd_en  = r_iss;
    assign ks_req.rd_idx = r_j;

    aesbe_keyexp #(.DEPTH(ROUND_KEY_DEPTH)) u_keyexp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (ks_req),
        .i_key_size (r_key_size),
        .i_key      (r_key),
        .o_done     (ks_done),
        .o_rdata    (rk)
    );

    // one round column: SubBytes/ShiftRows, MixColumns if used, AddRoundKey
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            tmp[k] = r_nx[k];
        end
        for (int r = 0; r < 4; r++) begin
            if (rnd == 4'd0) begin
                sb[r] = r_st[{col, 2'(r)}];
            end else begin
                sb[r] = sbox(r_st[{2'(col + 2'(r)), 2'(r)}]);
            end
        end
        all_x = sb[0] ^ sb[1] ^ sb[2] ^ sb[3];
        if (rnd != 4'd0 && rnd != nr) begin
            tmp[{col, 2'd0}] = sb[0] ^ all_x ^ xtime(sb[0] ^ sb[1]) ^ rk[31:24];
            tmp[{col, 2'd1}] = sb[1] ^ all_x ^ xtime(sb[1] ^ sb[2]) ^ rk[23:16];
            tmp[{col, 2'd2}] = sb[2] ^ all_x ^ xtime(sb[2] ^ sb[3]) ^ rk[15:8];
            tmp[{col, 2'd3}] = sb[3] ^ all_x ^ xtime(sb[3] ^ sb[0]) ^ rk[7:0];
        end else begin
            tmp[{col, 2'd0}] = sb[0] ^ rk[31:24];
            tmp[{col, 2'd1}] = sb[1] ^ rk[23:16];
            tmp[{col, 2'd2}] = sb[2] ^ rk[15:8];
            tmp[{col, 2'd3}] = sb[3] ^ rk[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_busy     <= 1'b0;
            r_valid    <= 1'b0;
            r_go       <= 1'b0;
            r_iss      <= 1'b0;
            r_p        <= 1'b0;
            r_key_size <= 2'd0;
            r_key      <= '0;
        end else begin
            r_valid <= 1'b0;
            r_go    <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_KEY_SIZE) begin
                    r_key_size <= i_cfg_data[1:0];
                end else if (i_cfg_idx <= REG_KEY_24_31) begin
                    r_key[2'(i_cfg_idx - REG_KEY_0_7)] <= i_cfg_data;
                end
            end
            r_p  <= r_iss;
            r_pj <= r_j;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EXPAND;
                        r_busy  <= 1'b1;
                        r_go    <= 1'b1;
                        for (int k = 0; k < 8; k++) begin
                            r_st[k]     <= i_block_hi[63-8*k -: 8];
                            r_st[k + 8] <= i_block_lo[63-8*k -: 8];
                        end
                    end
                end
                S_EXPAND: begin
                    if (ks_done) begin
                        r_state <= S_RUN;
                        r_iss   <= 1'b1;
                        r_j     <= '0;
                    end
                end
                S_RUN: begin
                    if (r_iss) begin
                        if (r_j == last_j) begin
                            r_iss <= 1'b0;
                        end else begin
                            r_j <= r_j + RKI_W'(1);
                        end
                    end
                    if (r_p) begin
                        for (int k = 0; k < 16; k++) begin
                            r_nx[k] <= tmp[k];
                        end
                        if (col == 2'd3) begin
                            for (int k = 0; k < 16; k++) begin
                                r_st[k] <= tmp[k];
                            end
                        end
                        if (r_pj == last_j) begin
                            r_state <= S_IDLE;
                            r_busy  <= 1'b0;
                            r_valid <= 1'b1;
                            for (int k = 0; k < 8; k++) begin
                                r_hi[63-8*k -: 8] <= tmp[k];
                                r_lo[63-8*k -: 8] <= tmp[k + 8];
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy        = r_busy;
    assign o_valid     = r_valid;
    assign o_cipher_hi = r_hi;
    assign o_cipher_lo = r_lo;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("start accepted but block not busy");
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(r_state == S_RUN)))
        else $error("result outside of a finished run");
    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p |-> (r_pj <= last_j && r_state == S_RUN))
        else $error("round key word index past the last round");
`endif

endmodule
